FILE: rtl/gbfs_pkg.sv
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared types and constants for the grid breadth-first distance field block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbfs_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam int COST_W      = 12;
    localparam int ROW_FIELD_W = 6;
    localparam int COL_FIELD_W = 6;
    localparam int GRID_CFG_W  = 7;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 2;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 2'd2;

    localparam logic [GRID_CFG_W-1:0] GRID_RST   = 7'd1;
    localparam logic [COST_W-1:0]     LAYERS_RST = 12'd1000;

    typedef struct packed {
        logic occupied;
        logic walkable;
        logic active;
    } t_flags;

    typedef struct packed {
        logic              reached;
        logic [COST_W-1:0] cost;
    } t_cost;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              reached;
        logic              all_reached;
        logic [COST_W-1:0] layers_used;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/grid_bfs_distance_field.sv
// ----------------------------------------------------------------------------
// grid_bfs_distance_field
// Four-neighbour breadth-first distance field over a flag grid held in memory.
// ----------------------------------------------------------------------------
// One item at a time. A flag write or unknown kind goes from acceptance
// to S_EMIT, a cell read passes through S_RDWAIT first. A run first clears
// the whole cost memory, then sweeps the used grid once per layer: each cell
// is read and checked (S_CELL, S_CCHK), an open passable cell then probes its
// neighbours one by one (S_NBR, S_NCHK), and each layer ends in S_LEND; the
// single read port of the cell store serialises the probes. After reset the
// block runs a clearing pass over both memories and holds i_valid off with
// o_stall until it is done; configuration writes are taken throughout.
`default_nettype none

module grid_bfs_distance_field #(
    parameter int MAX_ROWS = gbfs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gbfs_pkg::MAX_COLS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_wr_en,
    input  wire  [gbfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [gbfs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input beats
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [1:0]                          i_kind,
    input  wire  [gbfs_pkg::ROW_FIELD_W-1:0]    i_row,
    input  wire  [gbfs_pkg::COL_FIELD_W-1:0]    i_col,
    input  wire                                 i_active,
    input  wire                                 i_walkable,
    input  wire                                 i_occupied,
    // result beats
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [gbfs_pkg::COST_W-1:0]         o_cost,
    output logic                                o_reached,
    output logic                                o_all_reached,
    output logic [gbfs_pkg::COST_W-1:0]         o_layers_used
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROWN_W = $clog2(MAX_ROWS + 1);
    localparam int COLN_W = $clog2(MAX_COLS + 1);
    localparam int GW     = gbfs_pkg::GRID_CFG_W;
    localparam int CW     = gbfs_pkg::COST_W;

    logic [GW-1:0]     r_grid_rows;
    logic [GW-1:0]     r_grid_cols;
    logic [CW-1:0]     r_max_layers;
    logic [ROWN_W-1:0] nr;
    logic [COLN_W-1:0] nc;
    logic [CW-1:0]     lim;

    logic              r_out_valid;
    gbfs_pkg::t_res    r_out;
    logic              res_valid;
    logic              res_take;
    gbfs_pkg::t_res    res;

    logic [ADDR_W-1:0] waddr;
    logic              flags_we;
    gbfs_pkg::t_flags  flags_wdata;
    logic              cost_we;
    gbfs_pkg::t_cost   cost_wdata;
    logic [ADDR_W-1:0] raddr;
    gbfs_pkg::t_flags  rd_flags;
    gbfs_pkg::t_cost   rd_cost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= gbfs_pkg::GRID_RST;
            r_grid_cols  <= gbfs_pkg::GRID_RST;
            r_max_layers <= gbfs_pkg::LAYERS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                gbfs_pkg::CFG_ROWS:   r_grid_rows  <= i_cfg_data[GW-1:0];
                gbfs_pkg::CFG_COLS:   r_grid_cols  <= i_cfg_data[GW-1:0];
                gbfs_pkg::CFG_LAYERS: r_max_layers <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // grid size saturates into 1..MAX, a zero layer limit acts as one
    always_comb begin
        if (r_grid_rows == '0) begin
            nr = ROWN_W'(1);
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            nr = ROWN_W'(MAX_ROWS);
        end else begin
            nr = ROWN_W'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            nc = COLN_W'(1);
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            nc = COLN_W'(MAX_COLS);
        end else begin
            nc = COLN_W'(r_grid_cols);
        end
        lim = (r_max_layers == '0) ? CW'(1) : r_max_layers;
    end

    gbfs_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_active      (i_active),
        .i_walkable    (i_walkable),
        .i_occupied    (i_occupied),
        .i_nr          (nr),
        .i_nc          (nc),
        .i_lim         (lim),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res         (res),
        .o_waddr       (waddr),
        .o_flags_we    (flags_we),
        .o_flags_wdata (flags_wdata),
        .o_cost_we     (cost_we),
        .o_cost_wdata  (cost_wdata),
        .o_raddr       (raddr),
        .i_rd_flags    (rd_flags),
        .i_rd_cost     (rd_cost)
    );

    gbfs_cell_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk         (i_clk),
        .i_waddr       (waddr),
        .i_flags_we    (flags_we),
        .i_flags_wdata (flags_wdata),
        .i_cost_we     (cost_we),
        .i_cost_wdata  (cost_wdata),
        .i_raddr       (raddr),
        .o_flags       (rd_flags),
        .o_cost        (rd_cost)
    );

    // output register: the next item may start while a result beat waits
    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cost        = r_out.cost;
    assign o_reached     = r_out.reached;
    assign o_all_reached = r_out.all_reached;
    assign o_layers_used = r_out.layers_used;

endmodule

`default_nettype wire

FILE: rtl/gbfs_cell_store.sv
// ----------------------------------------------------------------------------
// gbfs_cell_store
// Cell flag and cost memories: one write and one registered read per cycle,
// both memories addressed together on the read side.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfs_cell_store #(
    parameter  int DEPTH  = gbfs_pkg::MAX_ROWS_DEF * gbfs_pkg::MAX_COLS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire                   i_clk,
    input  wire  [ADDR_W-1:0]     i_waddr,
    input  wire                   i_flags_we,
    input  gbfs_pkg::t_flags      i_flags_wdata,
    input  wire                   i_cost_we,
    input  gbfs_pkg::t_cost       i_cost_wdata,
    input  wire  [ADDR_W-1:0]     i_raddr,
    output gbfs_pkg::t_flags      o_flags,
    output gbfs_pkg::t_cost       o_cost
);

    gbfs_pkg::t_flags mem_flags [DEPTH];
    gbfs_pkg::t_cost  mem_cost  [DEPTH];

    gbfs_pkg::t_flags r_flags;
    gbfs_pkg::t_cost  r_cost;

    always_ff @(posedge i_clk) begin
        if (i_flags_we) begin
            mem_flags[i_waddr] <= i_flags_wdata;
        end
        r_flags <= mem_flags[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cost_we) begin
            mem_cost[i_waddr] <= i_cost_wdata;
        end
        r_cost <= mem_cost[i_raddr];
    end

    assign o_flags = r_flags;
    assign o_cost  = r_cost;

endmodule

`default_nettype wire

FILE: rtl/gbfs_engine.sv
// ----------------------------------------------------------------------------
// gbfs_engine
// Item sequencer: flag writes, cost reads, and the layered fill that sweeps
// the used grid once per layer, pulling each open cell from its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfs_engine #(
    parameter  int MAX_ROWS = gbfs_pkg::MAX_ROWS_DEF,
    parameter  int MAX_COLS = gbfs_pkg::MAX_COLS_DEF,
    localparam int DEPTH    = MAX_ROWS * MAX_COLS,
    localparam int ADDR_W   = $clog2(DEPTH),
    localparam int ROWN_W   = $clog2(MAX_ROWS + 1),
    localparam int COLN_W   = $clog2(MAX_COLS + 1)
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input channel
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [1:0]                         i_kind,
    input  wire  [gbfs_pkg::ROW_FIELD_W-1:0]   i_row,
    input  wire  [gbfs_pkg::COL_FIELD_W-1:0]   i_col,
    input  wire                                i_active,
    input  wire                                i_walkable,
    input  wire                                i_occupied,
    // effective configuration
    input  wire  [ROWN_W-1:0]                  i_nr,
    input  wire  [COLN_W-1:0]                  i_nc,
    input  wire  [gbfs_pkg::COST_W-1:0]        i_lim,
    // result hand-off
    output logic                               o_res_valid,
    input  wire                                i_res_take,
    output gbfs_pkg::t_res                     o_res,
    // cell store
    output logic [ADDR_W-1:0]                  o_waddr,
    output logic                               o_flags_we,
    output gbfs_pkg::t_flags                   o_flags_wdata,
    output logic                               o_cost_we,
    output gbfs_pkg::t_cost                    o_cost_wdata,
    output logic [ADDR_W-1:0]                  o_raddr,
    input  gbfs_pkg::t_flags                   i_rd_flags,
    input  gbfs_pkg::t_cost                    i_rd_cost
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CW    = gbfs_pkg::COST_W;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_RDWAIT = 10'b0000000100,
        S_RCLR   = 10'b0000001000,
        S_CELL   = 10'b0000010000,
        S_CCHK   = 10'b0000100000,
        S_NBR    = 10'b0001000000,
        S_NCHK   = 10'b0010000000,
        S_LEND   = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } t_state;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

    t_state             r_state,       n_state;
    logic [ADDR_W-1:0]  r_clr_addr,    n_clr_addr;
    logic [ADDR_W-1:0]  r_base_addr,   n_base_addr;
    logic               r_base_ok,     n_base_ok;
    logic               r_inside,      n_inside;
    logic [ROW_W-1:0]   r_r,           n_r;
    logic [COL_W-1:0]   r_c,           n_c;
    logic [1:0]         r_dir,         n_dir;
    logic [CW-1:0]      r_layer,       n_layer;
    logic               r_changed,     n_changed;
    logic               r_unreached,   n_unreached;
    logic [CW-1:0]      r_layer_count, n_layer_count;
    logic               r_fill_done,   n_fill_done;
    logic [CW-1:0]      r_res_cost,    n_res_cost;
    logic               r_res_reached, n_res_reached;

    logic               in_acc;
    logic [ROW_W-1:0]   in_r;
    logic [COL_W-1:0]   in_c;
    logic               in_inside;
    logic               clr_last;
    logic               nb_ok;
    logic [ROW_W-1:0]   nb_r;
    logic [COL_W-1:0]   nb_c;
    logic               cell_open;
    logic               nb_feeds;
    logic               last_col;
    logic               last_row;
    logic [CW:0]        layer_nx;
    logic               filled;

    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);
    assign in_r      = ROW_W'(i_row);
    assign in_c      = COL_W'(i_col);
    assign in_inside = (int'(i_row) < MAX_ROWS) && (int'(i_col) < MAX_COLS);
    assign clr_last  = (r_clr_addr == ADDR_W'(DEPTH - 1));

    assign cell_open = i_rd_flags.active && i_rd_flags.walkable && !i_rd_flags.occupied
                       && !i_rd_cost.reached;
    assign nb_feeds  = i_rd_cost.reached && (i_rd_cost.cost == r_layer)
                       && i_rd_flags.active && i_rd_flags.walkable;
    assign last_col  = (COLN_W'(r_c) + COLN_W'(1)) == i_nc;
    assign last_row  = (ROWN_W'(r_r) + ROWN_W'(1)) == i_nr;
    assign layer_nx  = {1'b0, r_layer} + (CW+1)'(1);
    assign filled    = !r_unreached;

    always_comb begin
        nb_ok = 1'b0;
        nb_r  = r_r;
        nb_c  = r_c;
        unique case (r_dir)
            DIR_UP: begin
                nb_ok = (r_r != '0);
                nb_r  = r_r - ROW_W'(1);
            end
            DIR_RIGHT: begin
                nb_ok = (COLN_W'(r_c) + COLN_W'(1)) < i_nc;
                nb_c  = r_c + COL_W'(1);
            end
            DIR_DOWN: begin
                nb_ok = (ROWN_W'(r_r) + ROWN_W'(1)) < i_nr;
                nb_r  = r_r + ROW_W'(1);
            end
            DIR_LEFT: begin
                nb_ok = (r_c != '0);
                nb_c  = r_c - COL_W'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_base_addr   = r_base_addr;
        n_base_ok     = r_base_ok;
        n_inside      = r_inside;
        n_r           = r_r;
        n_c           = r_c;
        n_dir         = r_dir;
        n_layer       = r_layer;
        n_changed     = r_changed;
        n_unreached   = r_unreached;
        n_layer_count = r_layer_count;
        n_fill_done   = r_fill_done;
        n_res_cost    = r_res_cost;
        n_res_reached = r_res_reached;

        o_waddr       = addr_of(r_r, r_c);
        o_flags_we    = 1'b0;
        o_flags_wdata = '{occupied: i_occupied, walkable: i_walkable, active: i_active};
        o_cost_we     = 1'b0;
        o_cost_wdata  = '{reached: 1'b1, cost: r_layer + CW'(1)};
        o_raddr       = addr_of(r_r, r_c);

        unique case (r_state)
            S_INIT: begin
                // power-up clearing pass over both memories
                o_waddr       = r_clr_addr;
                o_flags_we    = 1'b1;
                o_flags_wdata = '0;
                o_cost_we     = 1'b1;
                o_cost_wdata  = '0;
                n_clr_addr    = r_clr_addr + ADDR_W'(1);
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_waddr = addr_of(in_r, in_c);
                o_raddr = addr_of(in_r, in_c);
                if (in_acc) begin
                    n_inside      = in_inside;
                    n_res_cost    = '0;
                    n_res_reached = 1'b0;
                    unique case (i_kind)
                        gbfs_pkg::KIND_WRITE: begin
                            o_flags_we = in_inside;
                            n_state    = S_EMIT;
                        end
                        gbfs_pkg::KIND_RUN: begin
                            n_base_addr = addr_of(in_r, in_c);
                            n_base_ok   = (int'(i_row) < int'(i_nr))
                                          && (int'(i_col) < int'(i_nc));
                            n_clr_addr  = '0;
                            n_state     = S_RCLR;
                        end
                        gbfs_pkg::KIND_READ: begin
                            n_state = S_RDWAIT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_res_reached = r_inside && i_rd_cost.reached;
                n_res_cost    = (r_inside && i_rd_cost.reached) ? i_rd_cost.cost : '0;
                n_state       = S_EMIT;
            end
            S_RCLR: begin
                // wipe every cost, planting the base on the way past
                o_waddr      = r_clr_addr;
                o_cost_we    = 1'b1;
                o_cost_wdata = '0;
                if (r_base_ok && (r_clr_addr == r_base_addr)) begin
                    o_cost_wdata.reached = 1'b1;
                end
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (clr_last) begin
                    n_layer     = '0;
                    n_r         = '0;
                    n_c         = '0;
                    n_changed   = 1'b0;
                    n_unreached = 1'b0;
                    n_state     = S_CELL;
                end
            end
            S_CELL: begin
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (cell_open) begin
                    n_dir   = DIR_UP;
                    n_state = S_NBR;
                end
            end
            S_NBR: begin
                o_raddr = addr_of(nb_r, nb_c);
                if (nb_ok) begin
                    n_state = S_NCHK;
                end else if (r_dir == DIR_LEFT) begin
                    n_unreached = 1'b1;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            S_NCHK: begin
                // a neighbour marked earlier in this layer reads back unreached or
                // at layer+1; neither feeds, so read/write overlap is harmless
                if (nb_feeds) begin
                    o_cost_we = 1'b1;
                    n_changed = 1'b1;
                end else if (r_dir == DIR_LEFT) begin
                    n_unreached = 1'b1;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = S_NBR;
                end
            end
            S_LEND: begin
                if (filled || (layer_nx >= {1'b0, i_lim})) begin
                    n_layer_count = layer_nx[CW-1:0];
                    n_fill_done   = filled;
                    n_state       = S_EMIT;
                end else if (!r_changed) begin
                    // stalled fill: report the limit
                    n_layer_count = i_lim;
                    n_fill_done   = 1'b0;
                    n_state       = S_EMIT;
                end else begin
                    n_layer     = layer_nx[CW-1:0];
                    n_r         = '0;
                    n_c         = '0;
                    n_changed   = 1'b0;
                    n_unreached = 1'b0;
                    n_state     = S_CELL;
                end
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // step to the next cell once the current one is settled
        if ((r_state == S_CCHK && !cell_open)
            || (r_state == S_NBR && !nb_ok && r_dir == DIR_LEFT)
            || (r_state == S_NCHK && (nb_feeds || r_dir == DIR_LEFT))) begin
            if (last_col) begin
                n_c = '0;
                if (last_row) begin
                    n_state = S_LEND;
                end else begin
                    n_r     = r_r + ROW_W'(1);
                    n_state = S_CELL;
                end
            end else begin
                n_c     = r_c + COL_W'(1);
                n_state = S_CELL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_clr_addr    <= '0;
            r_layer_count <= '0;
            r_fill_done   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_layer_count <= n_layer_count;
            r_fill_done   <= n_fill_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_addr   <= n_base_addr;
        r_base_ok     <= n_base_ok;
        r_inside      <= n_inside;
        r_r           <= n_r;
        r_c           <= n_c;
        r_dir         <= n_dir;
        r_layer       <= n_layer;
        r_changed     <= n_changed;
        r_unreached   <= n_unreached;
        r_res_cost    <= n_res_cost;
        r_res_reached <= n_res_reached;
    end

    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = '{cost: r_res_cost, reached: r_res_reached,
                           all_reached: r_fill_done, layers_used: r_layer_count};

    // sweep position stays inside the used grid
    a_cell_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> ((ROWN_W'(r_r) < i_nr) && (COLN_W'(r_c) < i_nc)))
        else $error("fill sweep left the used grid");

    // a layer only ends below the limit
    a_layer_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEND) |-> (r_layer < i_lim))
        else $error("layer count reached the limit inside the fill");

    // run clear hands straight over to the first layer
    a_clr_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RCLR && clr_last) |=> (r_state == S_CELL && r_layer == '0))
        else $error("run clear did not start layer zero");

    // a mark is only ever made after a neighbour read
    a_mark_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NCHK && o_cost_we) |-> ($past(r_state) == S_NBR))
        else $error("cost mark without a neighbour read");

endmodule

`default_nettype wire

FILE: tb/grid_bfs_distance_field_checker.sv
// ----------------------------------------------------------------------------
// grid_bfs_distance_field_checker
// Watches the configuration port and both beat channels of the distance field
// block. Keeps its own cell store and fill state, predicts every result beat
// when an input beat is taken, and compares result beats in order, field by
// field.
// ----------------------------------------------------------------------------

module grid_bfs_distance_field_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [gbfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [gbfs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_item_valid,
    input  wire                                 i_item_stall,
    input  wire  [1:0]                          i_kind,
    input  wire  [gbfs_pkg::ROW_FIELD_W-1:0]    i_row,
    input  wire  [gbfs_pkg::COL_FIELD_W-1:0]    i_col,
    input  wire                                 i_active,
    input  wire                                 i_walkable,
    input  wire                                 i_occupied,
    input  wire                                 i_res_valid,
    input  wire                                 i_res_stall,
    input  wire  [gbfs_pkg::COST_W-1:0]         i_cost,
    input  wire                                 i_reached,
    input  wire                                 i_all_reached,
    input  wire  [gbfs_pkg::COST_W-1:0]         i_layers_used,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    import gbfs_pkg::*;

    localparam int NCOL  = MAX_COLS_DEF;
    localparam int CELLS = MAX_ROWS_DEF * MAX_COLS_DEF;

    t_flags                cell_flag [CELLS];
    t_cost                 cell_dist [CELLS];
    logic [COST_W-1:0]     fill_layers;
    logic                  fill_done;
    logic [GRID_CFG_W-1:0] rows_reg;
    logic [GRID_CFG_W-1:0] cols_reg;
    logic [COST_W-1:0]     layer_cap;
    t_res                  answer_q [$];

    function automatic logic open_cell(input t_flags f);
        return f.active && f.walkable && !f.occupied;
    endfunction

    // Applies one input beat to the local store and returns its result beat.
    function automatic t_res answer_item(input logic [1:0] kind,
                                         input logic [ROW_FIELD_W-1:0] row,
                                         input logic [COL_FIELD_W-1:0] col,
                                         input t_flags f);
        t_res res;
        int   nr, nc, lim, layer, r, c, d, i, j, ar, ac;
        logic changed, filled, stop;
        res = '0;
        case (kind)
            KIND_WRITE: begin
                if (row < MAX_ROWS_DEF && col < MAX_COLS_DEF)
                    cell_flag[row * NCOL + col] = f;
            end
            KIND_RUN: begin
                nr  = (rows_reg == 0) ? 1 :
                      (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
                nc  = (cols_reg == 0) ? 1 :
                      (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
                lim = (layer_cap == 0) ? 1 : int'(layer_cap);
                for (i = 0; i < CELLS; i++)
                    cell_dist[i] = '0;
                // base gets cost 0 whatever its flags, but only inside the used grid
                if (row < nr && col < nc)
                    cell_dist[row * NCOL + col].reached = 1'b1;
                layer  = 0;
                filled = 1'b0;
                stop   = 1'b0;
                while (!stop) begin
                    changed = 1'b0;
                    for (r = 0; r < nr; r++) begin
                        for (c = 0; c < nc; c++) begin
                            i = r * NCOL + c;
                            if (cell_dist[i].reached && cell_dist[i].cost == COST_W'(layer)
                                    && cell_flag[i].active && cell_flag[i].walkable) begin
                                for (d = 0; d < 4; d++) begin
                                    ar = r + ((d == 0) ? -1 : ((d == 2) ? 1 : 0));
                                    ac = c + ((d == 1) ? 1 : ((d == 3) ? -1 : 0));
                                    if (ar >= 0 && ac >= 0 && ar < nr && ac < nc) begin
                                        j = ar * NCOL + ac;
                                        if (open_cell(cell_flag[j]) && !cell_dist[j].reached) begin
                                            cell_dist[j].reached = 1'b1;
                                            cell_dist[j].cost    = COST_W'(layer + 1);
                                            changed              = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    layer++;
                    filled = 1'b1;
                    for (r = 0; r < nr; r++)
                        for (c = 0; c < nc; c++)
                            if (open_cell(cell_flag[r * NCOL + c])
                                    && !cell_dist[r * NCOL + c].reached)
                                filled = 1'b0;
                    if (filled || layer >= lim) begin
                        stop = 1'b1;
                    end else if (!changed) begin
                        // nothing grew but cells remain: reported as the full limit
                        layer = lim;
                        stop  = 1'b1;
                    end
                end
                fill_layers = COST_W'(layer);
                fill_done   = filled;
            end
            KIND_READ: begin
                if (row < MAX_ROWS_DEF && col < MAX_COLS_DEF
                        && cell_dist[row * NCOL + col].reached) begin
                    res.reached = 1'b1;
                    res.cost    = cell_dist[row * NCOL + col].cost;
                end
            end
            default: ;
        endcase
        res.all_reached = fill_done;
        res.layers_used = fill_layers;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res seen;
        t_res want;
        int   k;
        if (!i_rst_n) begin
            for (k = 0; k < CELLS; k++) begin
                cell_flag[k] = '0;
                cell_dist[k] = '0;
            end
            fill_layers  = '0;
            fill_done    = 1'b0;
            rows_reg     = GRID_RST;
            cols_reg     = GRID_RST;
            layer_cap    = LAYERS_RST;
            answer_q.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_ROWS:   rows_reg  = i_cfg_data[GRID_CFG_W-1:0];
                    CFG_COLS:   cols_reg  = i_cfg_data[GRID_CFG_W-1:0];
                    CFG_LAYERS: layer_cap = i_cfg_data[COST_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                seen.cost        = i_cost;
                seen.reached     = i_reached;
                seen.all_reached = i_all_reached;
                seen.layers_used = i_layers_used;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result beat, cost %0d reached %0b all %0b layers %0d",
                             $time, seen.cost, seen.reached, seen.all_reached, seen.layers_used);
                    o_mismatches++;
                end else begin
                    want = answer_q.pop_front();
                    if (seen.cost !== want.cost) begin
                        $display("%0t: cost expected %0d, got %0d", $time, want.cost, seen.cost);
                        o_mismatches++;
                    end
                    if (seen.reached !== want.reached) begin
                        $display("%0t: reached expected %0b, got %0b",
                                 $time, want.reached, seen.reached);
                        o_mismatches++;
                    end
                    if (seen.all_reached !== want.all_reached) begin
                        $display("%0t: all_reached expected %0b, got %0b",
                                 $time, want.all_reached, seen.all_reached);
                        o_mismatches++;
                    end
                    if (seen.layers_used !== want.layers_used) begin
                        $display("%0t: layers_used expected %0d, got %0d",
                                 $time, want.layers_used, seen.layers_used);
                        o_mismatches++;
                    end
                end
            end
            if (i_item_valid && !i_item_stall)
                answer_q.push_back(answer_item(i_kind, i_row, i_col,
                    t_flags'{occupied: i_occupied, walkable: i_walkable, active: i_active}));
        end
        o_outstanding = answer_q.size();
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the grid distance field block with a directed set of cell writes,
// fills and reads, then random phases over several grid sizes and layer caps,
// with random gaps and result stalls. The checker beside the block predicts
// and compares every result beat; this top gives the verdict.
// ----------------------------------------------------------------------------

module testbench;
    import gbfs_pkg::*;

    localparam logic [1:0]           KIND_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int                   CYCLE_LIMIT = 30_000_000;
    localparam int                   PHASES      = 8;
    localparam int                   PHASE_ITEMS = 16;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    wire                    o_stall;
    logic [1:0]             i_kind;
    logic [ROW_FIELD_W-1:0] i_row;
    logic [COL_FIELD_W-1:0] i_col;
    logic                   i_active;
    logic                   i_walkable;
    logic                   i_occupied;
    wire                    o_valid;
    logic                   i_stall = 1'b0;
    wire  [COST_W-1:0]      o_cost;
    wire                    o_reached;
    wire                    o_all_reached;
    wire  [COST_W-1:0]      o_layers_used;

    int   mismatches;
    int   outstanding;
    int   cycles;
    logic item_taken = 1'b0;
    logic calm = 1'b0;
    int   calm_left = 0;
    int   stall_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    grid_bfs_distance_field u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_active       (i_active),
        .i_walkable     (i_walkable),
        .i_occupied     (i_occupied),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cost         (o_cost),
        .o_reached      (o_reached),
        .o_all_reached  (o_all_reached),
        .o_layers_used  (o_layers_used)
    );

    grid_bfs_distance_field_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_item_valid   (i_valid),
        .i_item_stall   (o_stall),
        .i_kind         (i_kind),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_active       (i_active),
        .i_walkable     (i_walkable),
        .i_occupied     (i_occupied),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_cost         (o_cost),
        .i_reached      (o_reached),
        .i_all_reached  (o_all_reached),
        .i_layers_used  (o_layers_used),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    // sampled at the edge so the driver sees the handshake without a race
    always @(posedge i_clk)
        item_taken <= i_valid && !o_stall;

    // result-side stalls, with calm windows where neither side idles
    always @(negedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(100, 400);
        end else begin
            calm_left--;
        end
        if (stall_left != 0)
            stall_left--;
        else if (!calm && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(1, 3);
        i_stall <= (stall_left != 0);
    end

    task automatic send_item(input logic [1:0] kind,
                             input logic [ROW_FIELD_W-1:0] row,
                             input logic [COL_FIELD_W-1:0] col,
                             input logic act, input logic walk, input logic occ);
        int gap;
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_row      <= row;
        i_col      <= col;
        i_active   <= act;
        i_walkable <= walk;
        i_occupied <= occ;
        do @(negedge i_clk); while (!item_taken);
        gap = 0;
        if (!calm) begin
            case ($urandom_range(0, 19))
                0, 1:        gap = $urandom_range(8, 40);
                2, 3, 4, 5,
                6, 7, 8:     gap = $urandom_range(1, 3);
                default:     gap = 0;
            endcase
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // registers only change once the block has answered everything
    task automatic set_cfg(input logic [CFG_DATA_W-1:0] rows_data,
                           input logic [CFG_DATA_W-1:0] cols_data,
                           input logic [CFG_DATA_W-1:0] layers_data);
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_ROWS;
        i_cfg_data  <= rows_data;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_COLS;
        i_cfg_data  <= cols_data;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_LAYERS;
        i_cfg_data  <= layers_data;
        @(negedge i_clk);
        // unused index, should be ignored
        i_cfg_idx   <= CFG_SPARE;
        i_cfg_data  <= CFG_DATA_W'($urandom);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("grid_bfs_distance_field: mismatch");
        $finish;
    end

    initial begin
        logic [GRID_CFG_W-1:0]  rows_v, cols_v;
        logic [CFG_DATA_W-1:0]  layers_v;
        logic [ROW_FIELD_W-1:0] row_v;
        logic [COL_FIELD_W-1:0] col_v;
        int                     nr, nc, ph, n, pick;
        logic                   in_grid;

        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx   = CFG_ROWS;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_kind      = KIND_WRITE;
        i_row       = '0;
        i_col       = '0;
        i_active    = 1'b0;
        i_walkable  = 1'b0;
        i_occupied  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 1x1 grid, cap 1000
        send_item(KIND_RUN,   0,  0,  0, 0, 0);     // base on an inactive cell
        send_item(KIND_READ,  0,  0,  0, 0, 0);     // still marked with cost 0
        send_item(KIND_WRITE, 63, 63, 1, 1, 1);     // far corner, kept but unused
        send_item(KIND_READ,  63, 63, 1, 1, 1);
        send_item(KIND_SPARE, 63, 0,  1, 0, 1);

        // 3x3 grid, zero cap acts as one layer
        set_cfg(12'd3, 12'd3, 12'd0);
        send_item(KIND_WRITE, 0, 0, 1, 1, 0);
        send_item(KIND_WRITE, 0, 1, 1, 1, 0);
        send_item(KIND_WRITE, 0, 2, 1, 1, 1);       // occupied
        send_item(KIND_WRITE, 1, 0, 1, 0, 0);       // active, not walkable
        send_item(KIND_WRITE, 1, 1, 1, 1, 0);
        send_item(KIND_RUN,   0, 0, 0, 0, 0);       // stops at the cap, not complete
        send_item(KIND_READ,  0, 1, 0, 0, 0);
        send_item(KIND_READ,  1, 1, 0, 0, 0);

        set_cfg(12'hF83, 12'd3, 12'd4095);
        send_item(KIND_RUN,   2, 2, 1, 1, 1);       // dead base, fill stalls
        send_item(KIND_READ,  2, 2, 0, 0, 0);
        send_item(KIND_RUN,   0, 0, 0, 0, 0);
        send_item(KIND_READ,  1, 1, 1, 1, 1);
        send_item(KIND_RUN,   0, 2, 0, 1, 0);       // occupied base still spreads
        send_item(KIND_RUN,   63, 63, 0, 0, 0);     // base outside the used grid
        send_item(KIND_READ,  63, 63, 0, 0, 0);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin rows_v = 7'd64;  cols_v = 7'd64;  end
                1:       begin rows_v = 7'd127; cols_v = 7'd1;   end
                2:       begin rows_v = 7'd0;   cols_v = 7'd100; end
                default: begin
                    rows_v = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(7, 8))
                                                         : 7'($urandom_range(1, 6));
                    cols_v = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(7, 8))
                                                         : 7'($urandom_range(1, 6));
                end
            endcase
            nr = (rows_v == 0) ? 1 : (rows_v > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_v);
            nc = (cols_v == 0) ? 1 : (cols_v > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_v);
            // big grids sweep slowly, so only a few layers there
            if (nr * nc > 64) begin
                layers_v = 12'($urandom_range(0, 3));
            end else begin
                case ($urandom_range(0, 3))
                    0:       layers_v = 12'd4095;
                    1:       layers_v = 12'($urandom_range(1, 4095));
                    2:       layers_v = 12'($urandom_range(0, 2));
                    default: layers_v = 12'd1000;
                endcase
            end
            set_cfg({5'($urandom), rows_v}, {5'($urandom), cols_v}, layers_v);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick    = (n < 5) ? 0 : $urandom_range(0, 99);
                in_grid = ($urandom_range(0, 99) < 85);
                row_v   = in_grid ? 6'($urandom_range(0, nr - 1)) : 6'($urandom_range(0, 63));
                col_v   = in_grid ? 6'($urandom_range(0, nc - 1)) : 6'($urandom_range(0, 63));
                if (pick < 45) begin
                    if ($urandom_range(0, 9) < 7)
                        send_item(KIND_WRITE, row_v, col_v, 1, 1, 0);
                    else
                        send_item(KIND_WRITE, row_v, col_v, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else if (pick < 60) begin
                    send_item(KIND_RUN, row_v, col_v, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else if (pick < 94) begin
                    send_item(KIND_READ, row_v, col_v, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    send_item(KIND_SPARE, 6'($urandom_range(0, 63)),
                              6'($urandom_range(0, 63)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end
        end

        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("grid_bfs_distance_field: match");
        else
            $display("grid_bfs_distance_field: mismatch");
        $finish;
    end

endmodule
